/* hdl/msvg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msvg_pkg
// Shared types and constants of the momentum signal unit with volatility gate.
// ----------------------------------------------------------------------------
package msvg_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int MEAN_DEPTH = 64;
  localparam int MEAN_AW    = 6;
  localparam int VOL_N      = 20;
  localparam int VOL_AW     = 5;
  localparam int RET_W      = 30;
  localparam int IDX_W      = 7;
  localparam int DIV_NW     = 36;
  localparam int DIV_DW     = 32;

  localparam logic [IDX_W-1:0]  BAR_SAT   = 7'd84;
  localparam logic [RET_W-1:0]  RET_LIMIT = 30'd268435456;
  localparam logic [VOL_AW-1:0] VOL_LAST  = 5'd19;
  localparam logic [IDX_W-1:0]  VOL_SPAN  = 7'd20;
  localparam logic [IDX_W-1:0]  MEAN_MAX  = 7'd64;

  localparam logic [1:0] REG_MA_LENGTH  = 2'd0;
  localparam logic [1:0] REG_SIGNAL_THR = 2'd1;
  localparam logic [1:0] REG_VOL_THR    = 2'd2;

  localparam logic [1:0] SIG_NEUTRAL = 2'd0;
  localparam logic [1:0] SIG_LONG    = 2'd1;
  localparam logic [1:0] SIG_SHORT   = 2'd2;

  typedef struct packed {
    logic signed [RET_W-1:0] ret;
    logic [IDX_W-1:0]        idx;
  } item_t;

  typedef struct packed {
    logic [DIV_DW-1:0] rem;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
    logic [5:0]        steps;
  } div_req_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_WRITE,
    B_SUM,
    B_DRAIN,
    B_MDIV,
    B_MWAIT,
    B_VSS,
    B_VTT,
    B_VRR,
    B_VOO,
    B_VUPD
  } back_state_t;

endpackage
`default_nettype wire

/* hdl/momentum_signal_with_volatility_gate_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// momentum_signal_with_volatility_gate_unit
// Momentum signal from a moving mean of bar returns, gated on volatility.
//
// Input channel: one close price per request (in_valid, in_stall). Output
// channel: one result per bar (out_valid, out_stall) with the signal, the
// Q24 score, the volatility gate flag and the warm flag.
// Configuration: cfg_valid/cfg_ready write channel, always ready; cfg_index
// selects ma_length, signal_threshold or the volatility threshold, other
// indexes are ignored. Write only while the unit is idle.
// The front computes the return with a 28-step serial divider, skipped when
// no division is needed, and hands it to a two-entry queue. The back reads
// the mean window from RAM one entry per cycle, divides the sum serially and
// runs the gate on one shared multiplier; its pass over each bar sets the
// sustained rate. A first bar or a saturated return skips the division.
// Reset restores the register defaults and clears the volatility history and
// counters; no clearing pass is needed. A stalled result holds in the output
// register while the front keeps taking requests until the queue fills.
// ----------------------------------------------------------------------------
module momentum_signal_with_volatility_gate_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [31:0]  close_price,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [1:0]        signal,
  output logic signed [29:0] score,
  output logic              volatile_enough,
  output logic              warm,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [28:0]  cfg_data
);

  logic [6:0]  ma_length;
  logic [28:0] signal_threshold;
  logic [28:0] vol_limit;

  logic            full;
  logic            push;
  msvg_pkg::item_t push_item;
  logic            pop;
  logic            not_empty;
  msvg_pkg::item_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ma_length        <= 7'd14;
      signal_threshold <= 29'd8389;
      vol_limit        <= 29'd16777;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        msvg_pkg::REG_MA_LENGTH:  ma_length        <= cfg_data[6:0];
        msvg_pkg::REG_SIGNAL_THR: signal_threshold <= cfg_data;
        msvg_pkg::REG_VOL_THR:    vol_limit        <= cfg_data;
        default: ;
      endcase
    end
  end

  msvg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .close_price (close_price),
    .in_stall    (in_stall),
    .full        (full),
    .push        (push),
    .push_item   (push_item)
  );

  msvg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  msvg_back u_back (
    .clk              (clk),
    .rst              (rst),
    .not_empty        (not_empty),
    .head             (head),
    .pop              (pop),
    .ma_length        (ma_length),
    .signal_threshold (signal_threshold),
    .vol_limit        (vol_limit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .signal           (signal),
    .score            (score),
    .volatile_enough  (volatile_enough),
    .warm             (warm)
  );

endmodule
`default_nettype wire

/* hdl/msvg_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msvg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msvg_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/msvg_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msvg_div
// Restoring divider, one quotient bit per cycle, with a preset remainder.
// ----------------------------------------------------------------------------
module msvg_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire msvg_pkg::div_req_t        req,
  output logic                           done,
  output logic [msvg_pkg::DIV_NW-1:0]    quot
);

  logic                        busy;
  logic [5:0]                  cnt;
  logic [msvg_pkg::DIV_DW-1:0] rem;
  logic [msvg_pkg::DIV_DW-1:0] den;
  logic [msvg_pkg::DIV_NW-1:0] q;
  logic [msvg_pkg::DIV_DW:0]   trial;
  logic [msvg_pkg::DIV_DW:0]   diff;
  logic                        ge;

  // The numerator shifts out at the top while quotient bits enter below.
  always_comb begin
    trial = {rem, q[msvg_pkg::DIV_NW-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= req.rem;
      q   <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= ge ? diff[msvg_pkg::DIV_DW-1:0] : trial[msvg_pkg::DIV_DW-1:0];
      q   <= {q[msvg_pkg::DIV_NW-2:0], ge};
    end
  end

  assign quot = q;

endmodule
`default_nettype wire

/* hdl/msvg_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msvg_queue
// Two-entry queue of bar returns between the front and back parts.
// ----------------------------------------------------------------------------
module msvg_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire msvg_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output msvg_pkg::item_t      head
);

  msvg_pkg::item_t mem [2];
  logic            wp;
  logic            rp;
  logic [1:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = mem[rp];

endmodule
`default_nettype wire

/* hdl/msvg_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msvg_front
// Accepts close prices, classifies each bar and works out its Q24 return.
// ----------------------------------------------------------------------------
module msvg_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [31:0]     close_price,
  output logic                 in_stall,
  input  wire logic            full,
  output logic                 push,
  output msvg_pkg::item_t      push_item
);

  msvg_pkg::front_state_t state, state_next;

  logic [31:0]                     prev_close;
  logic [msvg_pkg::IDX_W-1:0]      bar_count;
  logic [msvg_pkg::IDX_W-1:0]      idx;
  logic                            neg;
  logic signed [msvg_pkg::RET_W-1:0] ret;

  logic [31:0]                  diff_mag;
  logic                         neg_c;
  logic                         big;
  logic                         trivial;
  logic                         div_start;
  logic                         div_done;
  msvg_pkg::div_req_t           div_req;
  logic [msvg_pkg::DIV_NW-1:0]  quot;
  logic signed [msvg_pkg::RET_W-1:0] qs;

  always_comb begin
    neg_c    = close_price < prev_close;
    diff_mag = neg_c ? prev_close - close_price : close_price - prev_close;
    // A quotient of 16.0 or more saturates, so the division needs 28 bits only.
    big      = {4'b0, diff_mag} >= {prev_close, 4'b0};
    trivial  = (bar_count == '0) || (prev_close == '0);
    div_req.rem   = {4'b0, diff_mag[31:4]};
    div_req.num   = {diff_mag[3:0], 32'b0};
    div_req.den   = prev_close;
    div_req.steps = 6'd28;
    qs = $signed({1'b0, quot[28:0]});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      msvg_pkg::F_IDLE: begin
        if (in_valid) begin
          state_next = (trivial || big) ? msvg_pkg::F_PUSH : msvg_pkg::F_DIV;
        end
      end
      msvg_pkg::F_DIV: begin
        if (div_done) begin
          state_next = msvg_pkg::F_PUSH;
        end
      end
      msvg_pkg::F_PUSH: begin
        if (!full) begin
          state_next = msvg_pkg::F_IDLE;
        end
      end
      default: state_next = msvg_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state != msvg_pkg::F_IDLE;
    push      = (state == msvg_pkg::F_PUSH) && !full;
    div_start = (state == msvg_pkg::F_IDLE) && in_valid && !trivial && !big;
    push_item = '{ret: ret, idx: idx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= msvg_pkg::F_IDLE;
      bar_count <= '0;
    end else begin
      state <= state_next;
      if (state == msvg_pkg::F_IDLE && in_valid && bar_count < msvg_pkg::BAR_SAT) begin
        bar_count <= bar_count + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == msvg_pkg::F_IDLE && in_valid) begin
      prev_close <= close_price;
      idx        <= bar_count;
      neg        <= neg_c;
      if (trivial) begin
        ret <= '0;
      end else if (big) begin
        ret <= neg_c ? -$signed(msvg_pkg::RET_LIMIT) : $signed(msvg_pkg::RET_LIMIT);
      end
    end else if (state == msvg_pkg::F_DIV && div_done) begin
      ret <= neg ? -qs : qs;
    end
  end

  msvg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quot  (quot)
  );

endmodule
`default_nettype wire

/* hdl/msvg_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msvg_back
// Moving mean, volatility gate and result register for each queued return.
// ----------------------------------------------------------------------------
module msvg_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            not_empty,
  input  wire msvg_pkg::item_t head,
  output logic                 pop,
  input  wire logic [6:0]      ma_length,
  input  wire logic [28:0]     signal_threshold,
  input  wire logic [28:0]     vol_limit,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [1:0]           signal,
  output logic signed [29:0]   score,
  output logic                 volatile_enough,
  output logic                 warm
);

  msvg_pkg::back_state_t state, state_next;

  msvg_pkg::item_t                     item;
  logic [msvg_pkg::MEAN_AW-1:0]        wpos;
  logic [msvg_pkg::MEAN_AW-1:0]        cur;
  logic [msvg_pkg::IDX_W-1:0]          cnt;
  logic                                rd_pend;
  logic signed [35:0]                  sum;
  logic signed [msvg_pkg::RET_W-1:0]   score_r;
  logic [msvg_pkg::VOL_AW-1:0]         vpos;
  logic signed [msvg_pkg::RET_W-1:0]   vring [msvg_pkg::VOL_N];
  logic signed [34:0]                  vs;
  logic [61:0]                         vs2;
  logic [65:0]                         prod;
  logic [65:0]                         prod_ss;
  logic [65:0]                         prod_tt;
  logic [65:0]                         prod_rr;
  logic                                gate;

  logic [msvg_pkg::IDX_W-1:0]          w;
  logic                                ram_we;
  logic [msvg_pkg::MEAN_AW-1:0]        raddr;
  logic [msvg_pkg::RET_W-1:0]          rdata;
  logic                                div_start;
  logic                                div_done;
  msvg_pkg::div_req_t                  div_req;
  logic [msvg_pkg::DIV_NW-1:0]         quot;
  logic [35:0]                         sum_mag;
  logic signed [msvg_pkg::RET_W-1:0]   qs;
  logic [32:0]                         mul_a;
  logic [32:0]                         mul_b;
  logic [34:0]                         vs_mag;
  logic signed [msvg_pkg::RET_W-1:0]   old;
  logic [msvg_pkg::RET_W-1:0]          ret_mag;
  logic [msvg_pkg::RET_W-1:0]          old_mag;
  logic [msvg_pkg::RET_W-1:0]          score_mag;
  logic [67:0]                         lhs;
  logic [67:0]                         rhs;
  logic                                load;
  logic [1:0]                          sig_c;

  always_comb begin
    if (ma_length == '0) begin
      w = 7'd1;
    end else if (ma_length > msvg_pkg::MEAN_MAX) begin
      w = msvg_pkg::MEAN_MAX;
    end else begin
      w = ma_length;
    end
    sum_mag = sum[35] ? 36'(-sum) : 36'(sum);
    div_req.rem   = '0;
    div_req.num   = sum_mag;
    div_req.den   = {25'b0, w};
    div_req.steps = 6'd36;
    qs      = $signed({1'b0, quot[28:0]});
    vs_mag  = vs[34] ? 35'(-vs) : 35'(vs);
    old     = vring[vpos];
    ret_mag = item.ret[29] ? 30'(-item.ret) : 30'(item.ret);
    old_mag = old[29] ? 30'(-old) : 30'(old);
    score_mag = score_r[29] ? 30'(-score_r) : 30'(score_r);
    // Gate: n*S2 - S^2 >= n*(n-1)*thr^2, with n = 20.
    lhs = ({6'b0, vs2} << 4) + ({6'b0, vs2} << 2);
    rhs = {2'b0, prod_ss} + ({2'b0, prod_tt} << 8) + ({2'b0, prod_tt} << 6)
        + ({2'b0, prod_tt} << 5) + ({2'b0, prod_tt} << 4)
        + ({2'b0, prod_tt} << 3) + ({2'b0, prod_tt} << 2);
    sig_c = msvg_pkg::SIG_NEUTRAL;
    if (gate && score_mag > {1'b0, signal_threshold}) begin
      sig_c = score_r[29] ? msvg_pkg::SIG_SHORT : msvg_pkg::SIG_LONG;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      msvg_pkg::B_IDLE:  if (not_empty) state_next = msvg_pkg::B_WRITE;
      msvg_pkg::B_WRITE: state_next = msvg_pkg::B_SUM;
      msvg_pkg::B_SUM:   if (cnt == w - 7'd1) state_next = msvg_pkg::B_DRAIN;
      msvg_pkg::B_DRAIN: state_next = msvg_pkg::B_MDIV;
      msvg_pkg::B_MDIV:  state_next = msvg_pkg::B_MWAIT;
      msvg_pkg::B_MWAIT: if (div_done) state_next = msvg_pkg::B_VSS;
      msvg_pkg::B_VSS:   state_next = msvg_pkg::B_VTT;
      msvg_pkg::B_VTT:   state_next = msvg_pkg::B_VRR;
      msvg_pkg::B_VRR:   state_next = msvg_pkg::B_VOO;
      msvg_pkg::B_VOO:   state_next = msvg_pkg::B_VUPD;
      msvg_pkg::B_VUPD:  if (!out_valid || !out_stall) state_next = msvg_pkg::B_IDLE;
      default: state_next = msvg_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == msvg_pkg::B_IDLE) && not_empty;
    ram_we    = state == msvg_pkg::B_WRITE;
    raddr     = cur - cnt[msvg_pkg::MEAN_AW-1:0];
    div_start = state == msvg_pkg::B_MDIV;
    load      = (state == msvg_pkg::B_VUPD) && (!out_valid || !out_stall);
    mul_a     = '0;
    // The oldest square stays on the multiplier while the result waits.
    unique case (state)
      msvg_pkg::B_VSS:  mul_a = vs_mag[32:0];
      msvg_pkg::B_VTT:  mul_a = {4'b0, vol_limit};
      msvg_pkg::B_VRR:  mul_a = {3'b0, ret_mag};
      msvg_pkg::B_VOO:  mul_a = {3'b0, old_mag};
      msvg_pkg::B_VUPD: mul_a = {3'b0, old_mag};
      default: mul_a = '0;
    endcase
    mul_b = mul_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= msvg_pkg::B_IDLE;
      wpos      <= '0;
      vpos      <= '0;
      vs        <= '0;
      vs2       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < msvg_pkg::VOL_N; i++) begin
        vring[i] <= '0;
      end
    end else begin
      state   <= state_next;
      rd_pend <= state == msvg_pkg::B_SUM;
      if (state == msvg_pkg::B_WRITE) begin
        wpos <= wpos + 6'd1;
      end
      if (load) begin
        out_valid   <= 1'b1;
        vs2         <= vs2 + prod_rr[61:0] - prod[61:0];
        vs          <= vs + 35'(item.ret) - 35'(old);
        vring[vpos] <= item.ret;
        vpos        <= (vpos == msvg_pkg::VOL_LAST) ? '0 : vpos + 5'd1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (pop) begin
      item <= head;
    end
    if (state == msvg_pkg::B_WRITE) begin
      cur <= wpos;
      cnt <= '0;
      sum <= '0;
    end else begin
      if (state == msvg_pkg::B_SUM) begin
        cnt <= cnt + 7'd1;
      end
      if (rd_pend) begin
        sum <= sum + 36'($signed(rdata));
      end
    end
    if (state == msvg_pkg::B_MWAIT && div_done) begin
      // No score until the window holds w returns, ma_length clamped to 1 to 64.
      if ({1'b0, item.idx} + 8'd1 >= {1'b0, w}) begin
        score_r <= sum[35] ? -qs : qs;
      end else begin
        score_r <= '0;
      end
    end
    if (state == msvg_pkg::B_VTT) begin
      prod_ss <= prod;
    end
    if (state == msvg_pkg::B_VRR) begin
      prod_tt <= prod;
    end
    if (state == msvg_pkg::B_VOO) begin
      prod_rr <= prod;
      gate    <= lhs >= rhs;
    end
    if (load) begin
      signal          <= sig_c;
      score           <= score_r;
      volatile_enough <= gate;
      warm            <= item.idx >= w + msvg_pkg::VOL_SPAN;
    end
  end

  msvg_ram #(
    .WIDTH (msvg_pkg::RET_W),
    .DEPTH (msvg_pkg::MEAN_DEPTH)
  ) u_mean_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos),
    .wdata (item.ret),
    .raddr (raddr),
    .rdata (rdata)
  );

  msvg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quot  (quot)
  );

endmodule
`default_nettype wire

/* verif/momentum_signal_with_volatility_gate_unit_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// momentum_signal_with_volatility_gate_unit_test
// Self-checking bench for the momentum signal unit with volatility gate.
// Close prices go in with random gaps and result stalls. A bit-exact
// predictor of returns, moving mean and variance gate queues the expected
// result of each accepted bar, and a scoreboard compares every result.
// Several register settings are covered, the extremes among them.
// ----------------------------------------------------------------------------
module momentum_signal_with_volatility_gate_unit_test;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]        sig;
    logic signed [29:0] score;
    logic              gate;
    logic              warm;
  } bar_result_t;

  class bar_scoreboard;
    bit [6:0]  ma_len;
    bit [28:0] sig_thr;
    bit [28:0] vol_thr;
    bit [31:0] prev_close;
    longint    mean_hist[msvg_pkg::MEAN_DEPTH];
    longint    vol_hist[msvg_pkg::VOL_N];
    int        bar_idx;
    int        mean_wr;
    int        vol_wr;
    bar_result_t pending[$];
    int        errors;

    function void clear();
      ma_len = 14;
      sig_thr = 8389;
      vol_thr = 16777;
      prev_close = 0;
      foreach (mean_hist[i]) mean_hist[i] = 0;
      foreach (vol_hist[i]) vol_hist[i] = 0;
      bar_idx = 0;
      mean_wr = 0;
      vol_wr = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [28:0] val);
      if (idx == msvg_pkg::REG_MA_LENGTH) ma_len = val[6:0];
      else if (idx == msvg_pkg::REG_SIGNAL_THR) sig_thr = val;
      else if (idx == msvg_pkg::REG_VOL_THR) vol_thr = val;
    endfunction

    function void note_bar(logic [31:0] close);
      longint w, ret, d, msum, vsum, score;
      logic [127:0] sq, lhs, rhs, m;
      bar_result_t r;
      w = ma_len;
      if (w < 1) w = 1;
      if (w > msvg_pkg::MEAN_DEPTH) w = msvg_pkg::MEAN_DEPTH;
      ret = 0;
      if (bar_idx != 0 && prev_close != 0) begin
        d = longint'(close) - longint'(prev_close);
        ret = (d * (longint'(1) << msvg_pkg::FRAC_BITS)) / longint'(prev_close);
        if (ret > 268435456) ret = 268435456;
        if (ret < -268435456) ret = -268435456;
      end
      mean_hist[mean_wr] = ret;
      mean_wr = (mean_wr + 1) % msvg_pkg::MEAN_DEPTH;
      msum = 0;
      for (int k = 0; k < w; k++)
        msum += mean_hist[(mean_wr + msvg_pkg::MEAN_DEPTH - 1 - k) % msvg_pkg::MEAN_DEPTH];
      score = 0;
      if (bar_idx + 1 >= w) score = msum / w;
      vsum = 0;
      sq = 0;
      for (int k = 0; k < msvg_pkg::VOL_N; k++) begin
        vsum += vol_hist[k];
        m = (vol_hist[k] < 0) ? -vol_hist[k] : vol_hist[k];
        sq += m * m;
      end
      // Sample variance test without a root: n*S2 - S^2 >= n*(n-1)*thr^2.
      lhs = sq * msvg_pkg::VOL_N;
      m = (vsum < 0) ? -vsum : vsum;
      rhs = m * m + 128'(vol_thr) * vol_thr * (msvg_pkg::VOL_N * (msvg_pkg::VOL_N - 1));
      vol_hist[vol_wr] = ret;
      vol_wr = (vol_wr + 1) % msvg_pkg::VOL_N;
      r.gate = lhs >= rhs;
      r.warm = bar_idx >= w + msvg_pkg::VOL_N;
      r.score = score[29:0];
      r.sig = msvg_pkg::SIG_NEUTRAL;
      if (r.gate && ((score < 0) ? -score : score) > longint'(sig_thr))
        r.sig = (score > 0) ? msvg_pkg::SIG_LONG : msvg_pkg::SIG_SHORT;
      prev_close = close;
      if (bar_idx < 84) bar_idx++;
      pending = {pending, r};
    endfunction

    function void check_result(logic [1:0] sig, logic signed [29:0] sc, logic g, logic wm);
      bar_result_t e;
      if (pending.size() == 0) begin
        $error("result with no bar waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (sig !== e.sig) begin
        $error("signal: expected %0d, actual %0d", e.sig, sig); errors++;
      end
      if (sc !== e.score) begin
        $error("score: expected %0d, actual %0d", e.score, sc); errors++;
      end
      if (g !== e.gate) begin
        $error("volatile_enough: expected %0d, actual %0d", e.gate, g); errors++;
      end
      if (wm !== e.warm) begin
        $error("warm: expected %0d, actual %0d", e.warm, wm); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [31:0] close_price;
  logic [1:0] signal;
  logic signed [29:0] score;
  logic volatile_enough, warm;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [28:0] cfg_data;

  bar_scoreboard board;
  bit calm;
  int cycles;

  momentum_signal_with_volatility_gate_unit dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog and result checking on the rising edge.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (!rst && out_valid && !out_stall)
      board.check_result(signal, score, volatile_enough, warm);
  end

  // Receiver stalls in bursts.
  initial begin
    out_stall = 0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(15, 1)) @(negedge clk);
        out_stall <= 0;
      end
      repeat ($urandom_range(20, 1)) @(negedge clk);
    end
  end

  // Valid stays high after a request so that the next one can follow at once;
  // drain() drops it.
  task automatic send_bar(logic [31:0] close);
    if (!calm && $urandom_range(5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(15, 1)) @(negedge clk);
    end
    in_valid <= 1;
    close_price <= close;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_bar(close);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [28:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic random_walk(int count, int step);
    logic [31:0] p;
    p = $urandom_range(200000, 1000);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(15) == 0) p = $urandom;
      else p = p + $urandom_range(2 * step) - step;
      if (p == 0) p = 1;
      send_bar(p);
    end
  endtask

  initial begin
    board = new();
    board.clear();
    calm = 0;
    cycles = 0;
    in_valid = 0;
    close_price = 0;
    cfg_valid = 0;
    cfg_index = msvg_pkg::REG_MA_LENGTH;
    cfg_data = 0;
    rst = 1;
    repeat (3) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: first bar, huge moves both ways, a zero close and the bar after it.
    send_bar(32'd1);
    send_bar(32'hFFFF_FFFF);
    send_bar(32'd1);
    send_bar(32'd100);
    send_bar(32'd0);
    send_bar(32'd500);
    send_bar(32'h8000_0000);
    send_bar(32'h7FFF_FFFF);
    for (int i = 0; i < 12; i++) send_bar(32'd1000 + i * 3);
    drain();

    write_cfg(msvg_pkg::REG_MA_LENGTH, 29'd1);
    write_cfg(msvg_pkg::REG_SIGNAL_THR, 29'd0);
    write_cfg(msvg_pkg::REG_VOL_THR, 29'd0);
    write_cfg(REG_UNUSED, 29'h1FFF_FFFF);
    random_walk(150, 3000);
    drain();

    write_cfg(msvg_pkg::REG_MA_LENGTH, 29'd64);
    write_cfg(msvg_pkg::REG_SIGNAL_THR, 29'd268435456);
    write_cfg(msvg_pkg::REG_VOL_THR, 29'd268435456);
    random_walk(150, 60000);
    drain();

    write_cfg(msvg_pkg::REG_MA_LENGTH, 29'd0);
    write_cfg(msvg_pkg::REG_SIGNAL_THR, 29'h1FFF_FFFF);
    write_cfg(msvg_pkg::REG_VOL_THR, 29'h1FFF_FFFF);
    random_walk(100, 100);
    drain();

    write_cfg(msvg_pkg::REG_MA_LENGTH, 29'd127);
    write_cfg(msvg_pkg::REG_SIGNAL_THR, 29'd8000);
    write_cfg(msvg_pkg::REG_VOL_THR, 29'd10000);
    random_walk(150, 500);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_cfg(msvg_pkg::REG_MA_LENGTH, 29'($urandom_range(64, 1)));
      write_cfg(msvg_pkg::REG_SIGNAL_THR, 29'($urandom_range(200000)));
      write_cfg(msvg_pkg::REG_VOL_THR, 29'($urandom_range(400000)));
      if (phase == 3) calm = 1;
      random_walk(110, $urandom_range(5000, 10));
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
hdl/msvg_pkg.sv
hdl/msvg_ram.sv
hdl/msvg_div.sv
hdl/msvg_queue.sv
hdl/msvg_front.sv
hdl/msvg_back.sv
hdl/momentum_signal_with_volatility_gate_unit.sv
verif/momentum_signal_with_volatility_gate_unit_test.sv
